### hw/rtl/kvlp_pkg.sv
// ----------------------------------------------------------------------------
// kvlp_pkg
// shared types, field widths and codes of the key/value line parser
// ----------------------------------------------------------------------------
package kvlp_pkg;

   localparam int LINE_W     = 24;
   localparam int COL_W      = 16;
   localparam int RSP_LINE_W = 24;
   localparam int RSP_COL_W  = 16;
   localparam int CR_W       = 16;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [7:0] CHAR_LF     = 8'd10;
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3d;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;

   typedef enum logic [2:0] {
      KIND_KEY   = 3'd0,
      KIND_VALUE = 3'd1,
      KIND_CRRUN = 3'd2,
      KIND_ENTRY = 3'd3,
      KIND_ERROR = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      MODE_LINE_START,
      MODE_COMMENT,
      MODE_KEY,
      MODE_VALUE_START,
      MODE_PLAIN,
      MODE_QUOTED
   } mode_type;

   typedef struct packed {
      kind_type                kind;
      logic [7:0]              out_byte;
      logic [CR_W-1:0]         cr_run;
      logic [RSP_LINE_W-1:0]   line_number;
      logic [RSP_COL_W-1:0]    column;
      logic                    last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

### hw/rtl/key_value_line_parser.sv
// ----------------------------------------------------------------------------
// key_value_line_parser
// streaming parser for key=value text lines
// ----------------------------------------------------------------------------
// text enters on the req_ channel, one byte per transaction; req_tlast marks
// end of input and closes the current line, its byte being ignored.
// each byte is parsed in the cycle it is accepted and its zero, one or two
// results land in a four-entry result queue; the results are registered
// there and offered on the rsp_ channel once the results ahead are taken.
// rsp_tuser carries the kind, rsp_tlast marks the last result of one byte.
// throughput: one byte per cycle while each byte yields at most one result
// and the receiver takes every result; a byte yielding two results takes
// two transfers of the rsp_ port, and a stalled receiver also limits rate.
// req_tready is high while the queue has room for two results, so a stalled
// receiver fills the queue and then holds off the sender without loss.
// reset clears the parser state and empties the queue; after a syntax error
// the block reports it once and then accepts and drops all bytes until reset.
// ----------------------------------------------------------------------------
module key_value_line_parser
   import kvlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_byte, cr_run, line_number, column
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // last_of_run
);

   push_type   push;
   result_type rsp;
   logic       accept;

   assign accept = req_tvalid && req_tready;

   kvlp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .text_byte    (req_tdata),
      .end_of_input (req_tlast),
      .push         (push)
   );

   kvlp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp)
   );

   assign rsp_tdata = {rsp.column, rsp.line_number, rsp.cr_run, rsp.out_byte};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

### hw/rtl/kvlp_core.sv
// ----------------------------------------------------------------------------
// kvlp_core
// parser state and combinational step logic, up to two results per byte
// ----------------------------------------------------------------------------
module kvlp_core
   import kvlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] text_byte,
   input  logic       end_of_input,
   output push_type   push
);

   mode_type              mode_ff, mode_in;
   logic [7:0]            held_ff, held_in;
   logic                  held_valid_ff, held_valid_in;
   logic [7:0]            quote_ff, quote_in;
   logic [CR_W-1:0]       pend_ff, pend_in;
   logic [LINE_W-1:0]     line_ff, line_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [COL_W-1:0]      first_cr_ff, first_cr_in;
   logic                  halted_ff, halted_in;

   logic [LINE_W-1:0]     lnum;
   logic [COL_W-1:0]      col_inc;
   logic [COL_W-1:0]      past_end;
   result_type            r0, r1;
   logic [1:0]            cnt;

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
   endfunction

   function automatic logic is_alnum(input logic [7:0] b);
      return is_alpha(b) || (b >= 8'h30 && b <= 8'h39);
   endfunction

   function automatic result_type mk(input kind_type k, input logic [7:0] b,
                                     input logic [CR_W-1:0] run,
                                     input logic [COL_W-1:0] col,
                                     input logic [LINE_W-1:0] ln);
      result_type r;
      r.kind        = k;
      r.out_byte    = b;
      r.cr_run      = run;
      r.line_number = RSP_LINE_W'(ln);
      r.column      = RSP_COL_W'(col);
      r.last        = 1'b0;
      return r;
   endfunction

   assign lnum     = (line_ff == {LINE_W{1'b1}}) ? line_ff : line_ff + 1'b1;
   assign col_inc  = (col_ff == {COL_W{1'b1}}) ? col_ff : col_ff + 1'b1;
   assign past_end = (pend_ff != '0) ? first_cr_ff : col_inc;

   always_comb begin
      mode_in       = mode_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      quote_in      = quote_ff;
      pend_in       = pend_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      first_cr_in   = first_cr_ff;
      halted_in     = halted_ff;
      r0            = mk(KIND_KEY, 8'd0, '0, '0, lnum);
      r1            = r0;
      cnt           = 2'd0;
      if (accept && !halted_ff) begin
         if (end_of_input || text_byte == CHAR_LF) begin
            unique case (mode_ff)
               MODE_KEY: begin
                  r0 = mk(KIND_ERROR, 8'd0, '0, past_end, lnum);
                  cnt = 2'd1;
                  halted_in = 1'b1;
               end
               MODE_VALUE_START: begin
                  r0 = mk(KIND_ENTRY, 8'd0, '0, '0, lnum);
                  cnt = 2'd1;
               end
               MODE_PLAIN: begin
                  if (held_valid_ff) begin
                     r0 = mk(KIND_VALUE, held_ff, '0, '0, lnum);
                     r1 = mk(KIND_ENTRY, 8'd0, '0, '0, lnum);
                     cnt = 2'd2;
                  end else begin
                     r0 = mk(KIND_ENTRY, 8'd0, '0, '0, lnum);
                     cnt = 2'd1;
                  end
               end
               MODE_QUOTED: begin
                  if (held_valid_ff && held_ff == quote_ff) begin
                     r0 = mk(KIND_ENTRY, 8'd0, '0, '0, lnum);
                  end else begin
                     r0 = mk(KIND_ERROR, 8'd0, '0, past_end, lnum);
                     halted_in = 1'b1;
                  end
                  cnt = 2'd1;
               end
               default: begin
               end
            endcase
            mode_in       = MODE_LINE_START;
            held_in       = 8'd0;
            held_valid_in = 1'b0;
            pend_in       = '0;
            col_in        = '0;
            first_cr_in   = '0;
            line_in       = lnum;
         end else begin
            col_in = col_inc;
            if (mode_ff == MODE_COMMENT) begin
            end else if (text_byte == CHAR_CR) begin
               if (pend_ff == '0) first_cr_in = col_inc;
               if (pend_ff != {CR_W{1'b1}}) pend_in = pend_ff + 1'b1;
            end else if (pend_ff != '0 && mode_ff != MODE_QUOTED) begin
               r0 = mk(KIND_ERROR, 8'd0, '0, first_cr_ff, lnum);
               cnt = 2'd1;
               halted_in = 1'b1;
            end else begin
               unique case (mode_ff)
                  MODE_LINE_START: begin
                     if (text_byte == CHAR_HASH) begin
                        mode_in = MODE_COMMENT;
                     end else if (is_alpha(text_byte)) begin
                        held_in = text_byte;
                        held_valid_in = 1'b1;
                        mode_in = MODE_KEY;
                     end else begin
                        r0 = mk(KIND_ERROR, 8'd0, '0, col_inc, lnum);
                        cnt = 2'd1;
                        halted_in = 1'b1;
                     end
                  end
                  MODE_KEY: begin
                     if (text_byte == CHAR_EQUAL || is_alnum(text_byte)) begin
                        if (held_valid_ff) begin
                           r0 = mk(KIND_KEY, held_ff, '0, '0, lnum);
                           cnt = 2'd1;
                        end
                        if (text_byte == CHAR_EQUAL) begin
                           held_valid_in = 1'b0;
                           mode_in = MODE_VALUE_START;
                        end else begin
                           held_in = text_byte;
                           held_valid_in = 1'b1;
                        end
                     end else begin
                        r0 = mk(KIND_ERROR, 8'd0, '0, col_inc, lnum);
                        cnt = 2'd1;
                        halted_in = 1'b1;
                     end
                  end
                  MODE_VALUE_START: begin
                     if (text_byte == CHAR_SQUOTE || text_byte == CHAR_DQUOTE) begin
                        quote_in = text_byte;
                        held_valid_in = 1'b0;
                        mode_in = MODE_QUOTED;
                     end else if (is_alnum(text_byte)) begin
                        held_in = text_byte;
                        held_valid_in = 1'b1;
                        mode_in = MODE_PLAIN;
                     end else begin
                        r0 = mk(KIND_ERROR, 8'd0, '0, col_inc, lnum);
                        cnt = 2'd1;
                        halted_in = 1'b1;
                     end
                  end
                  MODE_PLAIN: begin
                     if (is_alnum(text_byte)) begin
                        if (held_valid_ff) begin
                           r0 = mk(KIND_VALUE, held_ff, '0, '0, lnum);
                           cnt = 2'd1;
                        end
                        held_in = text_byte;
                        held_valid_in = 1'b1;
                     end else begin
                        r0 = mk(KIND_ERROR, 8'd0, '0, col_inc, lnum);
                        cnt = 2'd1;
                        halted_in = 1'b1;
                     end
                  end
                  MODE_QUOTED: begin
                     if (held_valid_ff && pend_ff != '0) begin
                        r0 = mk(KIND_VALUE, held_ff, '0, '0, lnum);
                        r1 = mk(KIND_CRRUN, 8'd0, pend_ff, '0, lnum);
                        cnt = 2'd2;
                     end else if (held_valid_ff) begin
                        r0 = mk(KIND_VALUE, held_ff, '0, '0, lnum);
                        cnt = 2'd1;
                     end else if (pend_ff != '0) begin
                        r0 = mk(KIND_CRRUN, 8'd0, pend_ff, '0, lnum);
                        cnt = 2'd1;
                     end
                     pend_in = '0;
                     first_cr_in = '0;
                     held_in = text_byte;
                     held_valid_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
      if (cnt == 2'd1) r0.last = 1'b1;
      if (cnt == 2'd2) r1.last = 1'b1;
      push.count = cnt;
      push.r0    = r0;
      push.r1    = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_LINE_START;
         held_ff       <= 8'd0;
         held_valid_ff <= 1'b0;
         quote_ff      <= 8'd0;
         pend_ff       <= '0;
         line_ff       <= '0;
         col_ff        <= '0;
         first_cr_ff   <= '0;
         halted_ff     <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         quote_ff      <= quote_in;
         pend_ff       <= pend_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         first_cr_ff   <= first_cr_in;
         halted_ff     <= halted_in;
      end
   end

`ifndef ASSERT_OFF
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> push.count == 2'd0)
      else $error("result produced while halted");
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0 && push.r0.kind == KIND_ERROR) |=> halted_ff)
      else $error("syntax error did not halt the parser");
   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> (!push.r0.last && push.r1.last))
      else $error("last flag misplaced on result pair");
`endif

endmodule

### hw/rtl/kvlp_rsp_fifo.sv
// ----------------------------------------------------------------------------
// kvlp_rsp_fifo
// small result queue, two writes and one read per cycle
// ----------------------------------------------------------------------------
module kvlp_rsp_fifo
   import kvlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       space,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   result_type           mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in;
   logic [FIFO_AW-1:0]   rd_ff, rd_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 pop;
   logic [FIFO_AW-1:0]   wr_next;

   assign space     = count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem[rd_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign wr_next   = wr_ff + 1'b1;

   always_comb begin
      wr_in    = wr_ff + FIFO_AW'(push.count);
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem[wr_ff] <= push.r0;
      if (push.count == 2'd2) mem[wr_next] <= push.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("result queue overflow");
   a_push_needs_space: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> space)
      else $error("results pushed without room");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the key/value line parser
// ----------------------------------------------------------------------------
// text bytes stream in from a queue, one transaction each; every accepted
// byte runs through a bit-exact parser model whose results are compared with
// the rsp_ stream field by field. the run keeps to well-formed lines with
// random content under four idling mixes, then ends with one syntax error of
// a random sort, since the block stays halted after it.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import kvlp_pkg::*;

   typedef struct packed {
      logic [7:0] text;
      logic       stop;
   } text_item_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // text_byte
   logic        req_tlast  = 1'b0;   // end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // out_byte, cr_run, line_number, column
   logic [2:0]  rsp_tuser;           // kind
   logic        rsp_tlast;           // last_of_run

   key_value_line_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   text_item_type text_to_send[$];
   result_type    parse_results_due[$];
   result_type    step_results[$];
   text_item_type next_text;
   result_type    due;
   int unsigned send_idle_pct  = 0;
   int unsigned take_stall_pct = 0;
   int unsigned bytes_queued   = 0;
   int unsigned mismatch_count = 0;
   bit          hold_go        = 1'b0;
   bit          hold_done      = 1'b0;

   // parser model state
   mode_type         cur_mode     = MODE_LINE_START;
   logic [7:0]       held_char    = 8'd0;
   logic             held_live    = 1'b0;
   logic [7:0]       open_quote   = 8'd0;
   logic [CR_W-1:0]  cr_pending   = '0;
   logic [LINE_W-1:0] lines_done  = '0;
   logic [COL_W-1:0] line_col     = '0;
   logic [COL_W-1:0] cr_start_col = '0;
   logic             stopped      = 1'b0;

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      mismatch_count++;
   endtask

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_alnum(logic [7:0] c);
      return is_letter(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic logic [COL_W-1:0] col_inc(logic [COL_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic logic [LINE_W-1:0] line_inc(logic [LINE_W-1:0] l);
      return (l == '1) ? l : l + 1'b1;
   endfunction

   function automatic void add_result(kind_type k, logic [7:0] b, logic [CR_W-1:0] run,
                                      logic [RSP_COL_W-1:0] col);
      result_type r;
      r.kind        = k;
      r.out_byte    = b;
      r.cr_run      = run;
      r.line_number = line_inc(lines_done);
      r.column      = col;
      r.last        = 1'b0;
      step_results.insert(step_results.size(), r);
   endfunction

   function automatic void raise_error(logic [COL_W-1:0] col);
      stopped = 1'b1;
      add_result(KIND_ERROR, 8'd0, '0, col);
   endfunction

   function automatic void predict_parse(logic [7:0] b, logic eoi);
      logic [COL_W-1:0] past_end;
      step_results.delete();
      if (!stopped) begin
         if (eoi || b == CHAR_LF) begin
            past_end = (cr_pending != 0) ? cr_start_col : col_inc(line_col);
            case (cur_mode)
               MODE_KEY: raise_error(past_end);
               MODE_VALUE_START: add_result(KIND_ENTRY, 8'd0, '0, '0);
               MODE_PLAIN: begin
                  if (held_live) add_result(KIND_VALUE, held_char, '0, '0);
                  add_result(KIND_ENTRY, 8'd0, '0, '0);
               end
               MODE_QUOTED: begin
                  if (held_live && held_char == open_quote)
                     add_result(KIND_ENTRY, 8'd0, '0, '0);
                  else
                     raise_error(past_end);
               end
               default: ;
            endcase
            cur_mode     = MODE_LINE_START;
            held_char    = 8'd0;
            held_live    = 1'b0;
            cr_pending   = '0;
            line_col     = '0;
            cr_start_col = '0;
            lines_done   = line_inc(lines_done);
         end else begin
            line_col = col_inc(line_col);
            if (cur_mode != MODE_COMMENT) begin
               if (b == CHAR_CR) begin
                  if (cr_pending == 0) cr_start_col = line_col;
                  if (cr_pending != '1) cr_pending = cr_pending + 1'b1;
               end else if (cr_pending != 0 && cur_mode != MODE_QUOTED) begin
                  raise_error(cr_start_col);
               end else begin
                  case (cur_mode)
                     MODE_LINE_START: begin
                        if (b == CHAR_HASH) begin
                           cur_mode = MODE_COMMENT;
                        end else if (is_letter(b)) begin
                           held_char = b;
                           held_live = 1'b1;
                           cur_mode  = MODE_KEY;
                        end else begin
                           raise_error(line_col);
                        end
                     end
                     MODE_KEY: begin
                        if (b == CHAR_EQUAL) begin
                           if (held_live) add_result(KIND_KEY, held_char, '0, '0);
                           held_live = 1'b0;
                           cur_mode  = MODE_VALUE_START;
                        end else if (is_alnum(b)) begin
                           if (held_live) add_result(KIND_KEY, held_char, '0, '0);
                           held_char = b;
                           held_live = 1'b1;
                        end else begin
                           raise_error(line_col);
                        end
                     end
                     MODE_VALUE_START: begin
                        if (b == CHAR_SQUOTE || b == CHAR_DQUOTE) begin
                           open_quote = b;
                           held_live  = 1'b0;
                           cur_mode   = MODE_QUOTED;
                        end else if (is_alnum(b)) begin
                           held_char = b;
                           held_live = 1'b1;
                           cur_mode  = MODE_PLAIN;
                        end else begin
                           raise_error(line_col);
                        end
                     end
                     MODE_PLAIN: begin
                        if (is_alnum(b)) begin
                           if (held_live) add_result(KIND_VALUE, held_char, '0, '0);
                           held_char = b;
                           held_live = 1'b1;
                        end else begin
                           raise_error(line_col);
                        end
                     end
                     default: begin
                        if (held_live) add_result(KIND_VALUE, held_char, '0, '0);
                        if (cr_pending != 0) add_result(KIND_CRRUN, 8'd0, cr_pending, '0);
                        cr_pending   = '0;
                        cr_start_col = '0;
                        held_char    = b;
                        held_live    = 1'b1;
                     end
                  endcase
               end
            end
         end
      end
      if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i])
         parse_results_due.insert(parse_results_due.size(), step_results[i]);
   endfunction

   // text sources

   function automatic void put(logic [7:0] b);
      text_to_send.insert(text_to_send.size(), text_item_type'{b, 1'b0});
      bytes_queued++;
   endfunction

   function automatic void put_str(string s);
      foreach (s[i]) put(s[i]);
   endfunction

   function automatic void put_eoi();
      text_to_send.insert(text_to_send.size(),
                          text_item_type'{8'($urandom_range(255)), 1'b1});
      bytes_queued++;
   endfunction

   function automatic void put_end();
      if ($urandom_range(9) == 0) put_eoi();
      else put(CHAR_LF);
   endfunction

   function automatic void put_crs(int unsigned n);
      repeat (n) put(CHAR_CR);
   endfunction

   function automatic logic [7:0] rand_alnum();
      int unsigned idx;
      idx = $urandom_range(61);
      if (idx < 10) return 8'("0" + idx);
      if (idx < 36) return 8'("A" + idx - 10);
      return 8'("a" + idx - 36);
   endfunction

   function automatic logic [7:0] rand_letter();
      int unsigned idx;
      idx = $urandom_range(51);
      return (idx < 26) ? 8'("A" + idx) : 8'("a" + idx - 26);
   endfunction

   function automatic logic [7:0] rand_not_lf();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      return (b == CHAR_LF) ? 8'd11 : b;
   endfunction

   // random byte that is neither alphanumeric, line end, carriage return,
   // nor one of two further excluded bytes
   function automatic logic [7:0] rand_bad(logic [7:0] skip_a, logic [7:0] skip_b);
      logic [7:0] b;
      b = 8'($urandom_range(255));
      while (is_alnum(b) || b == CHAR_LF || b == CHAR_CR || b == skip_a || b == skip_b)
         b = 8'($urandom_range(255));
      return b;
   endfunction

   function automatic void put_key();
      put(rand_letter());
      repeat ($urandom_range(7)) put(rand_alnum());
   endfunction

   function automatic void put_random_line();
      int unsigned sel;
      int unsigned vsel;
      logic [7:0]  q;
      sel = $urandom_range(99);
      if (sel < 10) begin
         put_crs($urandom_range(3));
      end else if (sel < 20) begin
         put(CHAR_HASH);
         repeat ($urandom_range(12)) put(rand_not_lf());
      end else begin
         put_key();
         put(CHAR_EQUAL);
         vsel = $urandom_range(3);
         if (vsel == 1) begin
            repeat ($urandom_range(1, 8)) put(rand_alnum());
         end else if (vsel >= 2) begin
            q = $urandom_range(1) ? CHAR_SQUOTE : CHAR_DQUOTE;
            put(q);
            repeat ($urandom_range(10)) begin
               if ($urandom_range(4) == 0) put_crs($urandom_range(1, 4));
               else put(rand_not_lf());
            end
            put(q);
         end
         if ($urandom_range(2) == 0) put_crs($urandom_range(1, 2));
      end
      put_end();
   endfunction

   function automatic void put_random_lines(int unsigned n);
      int unsigned target;
      target = bytes_queued + n;
      while (bytes_queued < target) put_random_line();
   endfunction

   function automatic void put_syntax_error();
      logic [7:0] q;
      q = $urandom_range(1) ? CHAR_SQUOTE : CHAR_DQUOTE;
      case ($urandom_range(8))
         0: put(rand_bad(CHAR_HASH, CHAR_HASH));
         1: begin
            put_key();
            put(rand_bad(CHAR_EQUAL, CHAR_EQUAL));
         end
         2: begin
            put_key();
            put_crs($urandom_range(2));
            put_end();
         end
         3: begin
            put_key();
            put_crs($urandom_range(1, 3));
            put(rand_alnum());
         end
         4: begin
            put_str("a=");
            put(q);
            put_crs($urandom_range(2));
            put_end();
         end
         5: begin
            put_str("a=");
            put(q);
            repeat ($urandom_range(1, 5)) put(rand_alnum());
            put_end();
         end
         6: begin
            put_str("a=b");
            put(rand_bad(CHAR_CR, CHAR_CR));
         end
         7: begin
            put_str("a=");
            put(rand_bad(CHAR_SQUOTE, CHAR_DQUOTE));
         end
         default: begin
            put_str("a=b");
            put(CHAR_CR);
            put(rand_alnum());
         end
      endcase
      // halted: none of this may produce a transaction
      put_str("x=y");
      put(CHAR_LF);
      repeat (8) put(rand_not_lf());
      put_eoi();
   endfunction

   task automatic wait_drained();
      while (text_to_send.size() != 0 || req_tvalid || parse_results_due.size() != 0)
         @(negedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_parse(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (text_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_text = text_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_text.text;
               req_tlast  <= next_text.stop;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(hold_go && !hold_done) && ($urandom_range(99) >= take_stall_pct);
      end
   end

   // long receiver hold-off
   initial begin
      wait (hold_go);
      repeat (400) @(negedge clock);
      hold_done = 1'b1;
   end

   // checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (parse_results_due.size() == 0) begin
            flag_mismatch("unexpected transaction", 64'(rsp_tuser), 64'd0);
         end else begin
            due = parse_results_due.pop_front();
            if (rsp_tuser !== due.kind)
               flag_mismatch("kind", 64'(rsp_tuser), 64'(due.kind));
            if (rsp_tdata[7:0] !== due.out_byte)
               flag_mismatch("out_byte", 64'(rsp_tdata[7:0]), 64'(due.out_byte));
            if (rsp_tdata[23:8] !== due.cr_run)
               flag_mismatch("cr_run", 64'(rsp_tdata[23:8]), 64'(due.cr_run));
            if (rsp_tdata[47:24] !== due.line_number)
               flag_mismatch("line_number", 64'(rsp_tdata[47:24]), 64'(due.line_number));
            if (rsp_tdata[63:48] !== due.column)
               flag_mismatch("column", 64'(rsp_tdata[63:48]), 64'(due.column));
            if (rsp_tlast !== due.last)
               flag_mismatch("last_of_run", 64'(rsp_tlast), 64'(due.last));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("[key_value_line_parser] ERROR");
      $finish;
   end

   initial begin
      put_str("#");
      put(CHAR_LF);
      put(CHAR_CR);
      put(CHAR_LF);
      put_str("A=");
      put_eoi();
      put_str("z9=Z0");
      put(CHAR_CR);
      put(CHAR_LF);
      put_str("k=");
      put(CHAR_DQUOTE);
      put(8'h00);
      put_crs(2);
      put(8'hff);
      put(CHAR_DQUOTE);
      put(CHAR_LF);
      put_str("q=");
      put(CHAR_SQUOTE);
      put(CHAR_SQUOTE);
      put(CHAR_LF);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      hold_go = 1'b1;
      put_random_lines(440);
      wait_drained();

      send_idle_pct = 86;
      take_stall_pct = 0;
      put_random_lines(440);
      wait_drained();

      send_idle_pct = 0;
      take_stall_pct = 86;
      put_random_lines(440);
      wait_drained();

      send_idle_pct = 15;
      take_stall_pct = 15;
      put_random_lines(440);
      wait_drained();

      send_idle_pct = 0;
      take_stall_pct = 0;
      put_syntax_error();
      wait_drained();
      repeat (20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("[key_value_line_parser] OK");
      end else begin
         $display("[key_value_line_parser] ERROR");
      end
      $finish;
   end

endmodule
